@@ sv/sled_pkg.sv @@
`default_nettype none

package sled_pkg;

    // Datapath operations; the controller state vector uses the same codes
    typedef logic [4:0] t_op;

    localparam t_op OP_IDLE  = 5'd0;
    localparam t_op OP_APPLY = 5'd1;
    localparam t_op OP_DIV1  = 5'd2;
    localparam t_op OP_DIV2  = 5'd3;
    localparam t_op OP_DIV3  = 5'd4;
    localparam t_op OP_FRAC1 = 5'd5;
    localparam t_op OP_FRAC2 = 5'd6;
    localparam t_op OP_FRAC3 = 5'd7;
    localparam t_op OP_ANGLE = 5'd8;
    localparam t_op OP_FSQ   = 5'd9;
    localparam t_op OP_H9    = 5'd10;
    localparam t_op OP_H7    = 5'd11;
    localparam t_op OP_H5    = 5'd12;
    localparam t_op OP_H3    = 5'd13;
    localparam t_op OP_H1    = 5'd14;
    localparam t_op OP_LVL   = 5'd15;
    localparam t_op OP_LEV16 = 5'd16;
    localparam t_op OP_PCT   = 5'd17;
    localparam t_op OP_SC1   = 5'd18;
    localparam t_op OP_SC2   = 5'd19;

    // Display state codes
    typedef logic [2:0] t_disp;

    localparam t_disp DS_BOOT   = 3'd0;
    localparam t_disp DS_READY  = 3'd1;
    localparam t_disp DS_SCAN   = 3'd2;
    localparam t_disp DS_NEWDEV = 3'd3;
    localparam t_disp DS_PORTAL = 3'd4;
    localparam t_disp DS_SAVING = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic  func;
        t_disp eff_state;
        t_disp shown;
        logic  out_busy;
    } t_status;

endpackage

`default_nettype wire

@@ sv/sled_ctrl.sv @@
`default_nettype none

module sled_ctrl import sled_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    t_op  r_state;
    t_op  n_state;
    logic r_pass;
    logic n_pass;

    // An item is taken only between operations
    assign o_in_ready = (r_state == OP_IDLE);

    // Step sequencing; the division steps run twice for the breathing level
    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_cmd.load = i_in_valid & o_in_ready;
        o_cmd.op   = r_state;
        case (r_state)
            OP_IDLE: begin
                if (o_cmd.load) begin
                    n_state = OP_APPLY;
                end
            end
            OP_APPLY: begin
                if (i_st.func) begin
                    n_state = OP_IDLE;
                end else if (i_st.eff_state inside {DS_BOOT, DS_SCAN, DS_NEWDEV}) begin
                    n_state = OP_DIV1;
                    n_pass  = 1'b0;
                end else begin
                    n_state = OP_SC1;
                end
            end
            OP_DIV1:  n_state = OP_DIV2;
            OP_DIV2:  n_state = OP_DIV3;
            OP_DIV3: begin
                if (i_st.shown != DS_BOOT) begin
                    n_state = OP_SC1;
                end else if (!r_pass) begin
                    n_state = OP_FRAC1;
                end else begin
                    n_state = OP_ANGLE;
                end
            end
            OP_FRAC1: n_state = OP_FRAC2;
            OP_FRAC2: n_state = OP_FRAC3;
            OP_FRAC3: begin
                n_state = OP_DIV1;
                n_pass  = 1'b1;
            end
            OP_ANGLE: n_state = OP_FSQ;
            OP_FSQ:   n_state = OP_H9;
            OP_H9:    n_state = OP_H7;
            OP_H7:    n_state = OP_H5;
            OP_H5:    n_state = OP_H3;
            OP_H3:    n_state = OP_H1;
            OP_H1:    n_state = OP_LVL;
            OP_LVL:   n_state = OP_LEV16;
            OP_LEV16: n_state = OP_PCT;
            OP_PCT:   n_state = OP_SC1;
            OP_SC1:   n_state = OP_SC2;
            OP_SC2: begin
                // Hold the finished colour back while the output stage is full
                if (i_st.out_busy) begin
                    o_cmd.op = OP_IDLE;
                end else begin
                    n_state = OP_IDLE;
                end
            end
            default:  n_state = OP_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

endmodule

`default_nettype wire

@@ sv/sled_dp.sv @@
`default_nettype none

module sled_dp import sled_pkg::*; #(
    parameter int unsigned BREATH_PERIOD_MS = 1500
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_st,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    input  wire logic        i_func,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [2:0]  i_new_state,
    input  wire logic [31:0] i_hold_ms,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [2:0]       o_shown_state
);

    localparam int unsigned IW = $clog2(BREATH_PERIOD_MS);
    localparam logic [63:0] TWO32 = 64'h1_0000_0000;

    // Divisors with their truncated reciprocals, floor(2^32 / d)
    localparam logic [31:0] DIV_P    = 32'(BREATH_PERIOD_MS);
    localparam logic [31:0] RCP_P    = 32'(TWO32 / BREATH_PERIOD_MS);
    localparam logic [31:0] RES_P    = 32'(TWO32 % BREATH_PERIOD_MS);
    localparam logic [31:0] DIV_SCAN = 32'd350;
    localparam logic [31:0] RCP_SCAN = 32'(TWO32 / 64'd350);
    localparam logic [31:0] DIV_NEW  = 32'd600;
    localparam logic [31:0] RCP_NEW  = 32'(TWO32 / 64'd600);

    localparam logic [1:0] DSEL_BREATH = 2'd0;
    localparam logic [1:0] DSEL_SCAN   = 2'd1;
    localparam logic [1:0] DSEL_NEW    = 2'd2;

    // Q30 sine polynomial coefficients
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic [31:0] SIN_C1  = 32'd1686629713;
    localparam logic [31:0] SIN_C3  = 32'd693598668;
    localparam logic [31:0] SIN_C5  = 32'd85569306;
    localparam logic [31:0] SIN_C7  = 32'd5026994;
    localparam logic [31:0] SIN_C9  = 32'd172272;

    localparam logic [23:0] COL_BLUE   = 24'h1040FF;
    localparam logic [23:0] COL_GREEN  = 24'h00C040;
    localparam logic [23:0] COL_YELLOW = 24'hC0A000;
    localparam logic [23:0] COL_VIOLET = 24'h8000C0;
    localparam logic [23:0] COL_CYAN   = 24'h00C0C0;

    localparam logic [6:0]  PCT_MAX   = 7'd100;
    localparam logic [6:0]  PCT_RESET = 7'd15;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
    localparam logic [12:0] DIV100_M  = 13'd5243;

    logic          r_func;
    logic [31:0]   r_now;
    t_disp         r_ns;
    logic [31:0]   r_hold;
    t_disp         r_disp;
    logic [31:0]   r_expiry;
    logic [6:0]    r_bright;
    t_disp         r_shown;
    logic [1:0]    r_dsel;
    logic [31:0]   r_x;
    logic [31:0]   r_q;
    logic [63:0]   r_prod;
    logic [IW-1:0] r_idx;
    logic [31:0]   r_a;
    logic [30:0]   r_f;
    logic [1:0]    r_quad;
    logic [30:0]   r_f2;
    logic [31:0]   r_lvl;
    logic [15:0]   r_level;
    logic [6:0]    r_pct;
    logic [14:0]   r_cr;
    logic [14:0]   r_cg;
    logic [14:0]   r_cb;
    logic          r_ovalid;
    logic [7:0]    r_red;
    logic [7:0]    r_green;
    logic [7:0]    r_blue;
    t_disp         r_ostate;

    logic          expired;
    t_disp         eff_state;
    logic [31:0]   div_d;
    logic [31:0]   div_r;
    logic [31:0]   diff;
    logic          ge;
    logic [31:0]   rem;
    logic [31:0]   ang;
    logic [30:0]   frac;
    logic [30:0]   fold;
    logic [30:0]   prod_q;
    logic [31:0]   h_c;
    logic [31:0]   h_s;
    logic [30:0]   s_clamp;
    logic [31:0]   lvl;
    logic [47:0]   wide;
    logic [22:0]   pct_prod;
    logic [6:0]    pct_use;
    logic [23:0]   colour;
    logic          blank;
    logic [27:0]   q_r;
    logic [27:0]   q_g;
    logic [27:0]   q_b;
    logic          mul_en;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;

    // Hold expiry is checked against the timestamp of the render item
    always_comb begin
        expired   = (r_expiry != 32'd0) && (r_now >= r_expiry);
        eff_state = expired ? DS_READY : r_disp;
    end

    // Divisor selection and quotient correction
    always_comb begin
        case (r_dsel)
            DSEL_SCAN: begin
                div_d = DIV_SCAN;
                div_r = RCP_SCAN;
            end
            DSEL_NEW: begin
                div_d = DIV_NEW;
                div_r = RCP_NEW;
            end
            default: begin
                div_d = DIV_P;
                div_r = RCP_P;
            end
        endcase
        diff = r_x - r_prod[31:0];
        ge   = (diff >= div_d);
        rem  = ge ? (diff - div_d) : diff;
    end

    // Turn fraction to quadrant and mirrored Q30 position
    always_comb begin
        ang  = r_a + r_q;
        frac = {1'b0, ang[29:0]};
        fold = ang[30] ? (Q30_ONE[30:0] - frac) : frac;
    end

    // Horner step: coefficient minus the previous product in Q30
    always_comb begin
        prod_q = r_prod[60:30];
        case (i_cmd.op)
            OP_H7:   h_c = SIN_C7;
            OP_H5:   h_c = SIN_C5;
            OP_H3:   h_c = SIN_C3;
            OP_H1:   h_c = SIN_C1;
            default: h_c = SIN_C7;
        endcase
        h_s = h_c - {1'b0, prod_q};
    end

    // Level from the clamped sine, then Q0.16 rounding
    always_comb begin
        s_clamp  = (prod_q > Q30_ONE[30:0]) ? Q30_ONE[30:0] : prod_q;
        lvl      = r_quad[1] ? (Q30_ONE - {1'b0, s_clamp}) : (Q30_ONE + {1'b0, s_clamp});
        wide     = {r_lvl, 16'd0} - {16'd0, r_lvl} + {16'd0, Q30_ONE};
        pct_prod = {16'd0, r_bright} * {7'd0, r_level};
    end

    // Colour and percentage for the shown state; blink off phases go dark
    always_comb begin
        case (r_shown)
            DS_BOOT:   colour = COL_BLUE;
            DS_READY:  colour = COL_BLUE;
            DS_SCAN:   colour = COL_GREEN;
            DS_NEWDEV: colour = COL_YELLOW;
            DS_PORTAL: colour = COL_VIOLET;
            default:   colour = COL_CYAN;
        endcase
        blank   = ((r_shown == DS_SCAN) || (r_shown == DS_NEWDEV)) && r_q[0];
        pct_use = (r_shown == DS_BOOT) ? r_pct : r_bright;
        q_r     = {13'd0, r_cr} * {15'd0, DIV100_M};
        q_g     = {13'd0, r_cg} * {15'd0, DIV100_M};
        q_b     = {13'd0, r_cb} * {15'd0, DIV100_M};
    end

    // Operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        case (i_cmd.op)
            OP_DIV1: begin
                mul_a = r_x;
                mul_b = div_r;
            end
            OP_DIV2: begin
                mul_a = r_prod[63:32];
                mul_b = div_d;
            end
            OP_FRAC1: begin
                mul_a = 32'(r_idx);
                mul_b = RCP_P;
            end
            OP_FRAC2: begin
                mul_a = 32'(r_idx);
                mul_b = RES_P;
            end
            OP_FSQ: begin
                mul_a = {1'b0, r_f};
                mul_b = {1'b0, r_f};
            end
            OP_H9: begin
                mul_a = {1'b0, prod_q};
                mul_b = SIN_C9;
            end
            OP_H7, OP_H5, OP_H3: begin
                mul_a = {1'b0, r_f2};
                mul_b = h_s;
            end
            OP_H1: begin
                mul_a = {1'b0, r_f};
                mul_b = h_s;
            end
            default: mul_en = 1'b0;
        endcase
    end

    // Display state, hold expiry and brightness
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp   <= DS_BOOT;
            r_expiry <= 32'd0;
            r_bright <= PCT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_bright <= (i_cfg_wr_data > PCT_MAX) ? PCT_MAX : i_cfg_wr_data;
            end
            if (i_cmd.op == OP_APPLY) begin
                if (r_func) begin
                    // Unknown state codes leave everything as it was
                    if (r_ns <= DS_SAVING) begin
                        r_disp   <= r_ns;
                        r_expiry <= (r_hold != 32'd0) ? (r_now + r_hold) : 32'd0;
                    end
                end else if (expired) begin
                    r_disp   <= DS_READY;
                    r_expiry <= 32'd0;
                end
            end
        end
    end

    // Output stage; it is refilled only once the previous colour is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_SC2) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Working registers of the datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_now  <= i_now_ms;
            r_ns   <= i_new_state;
            r_hold <= i_hold_ms;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.op)
            OP_APPLY: begin
                r_shown <= eff_state;
                r_x     <= r_now;
                case (eff_state)
                    DS_SCAN:   r_dsel <= DSEL_SCAN;
                    DS_NEWDEV: r_dsel <= DSEL_NEW;
                    default:   r_dsel <= DSEL_BREATH;
                endcase
            end
            OP_DIV2: begin
                r_q <= r_prod[63:32];
            end
            OP_DIV3: begin
                r_q   <= r_q + {31'd0, ge};
                r_idx <= rem[IW-1:0];
            end
            OP_FRAC2: begin
                r_a <= r_prod[31:0];
            end
            OP_FRAC3: begin
                r_x <= r_prod[31:0];
            end
            OP_ANGLE: begin
                r_f    <= fold;
                r_quad <= ang[31:30];
            end
            OP_H9: begin
                r_f2 <= prod_q;
            end
            OP_LVL: begin
                r_lvl <= lvl;
            end
            OP_LEV16: begin
                r_level <= wide[46:31];
            end
            OP_PCT: begin
                r_pct <= pct_prod[22:16];
            end
            OP_SC1: begin
                if (blank) begin
                    r_cr <= 15'd0;
                    r_cg <= 15'd0;
                    r_cb <= 15'd0;
                end else begin
                    r_cr <= {7'd0, colour[23:16]} * {8'd0, pct_use};
                    r_cg <= {7'd0, colour[15:8]} * {8'd0, pct_use};
                    r_cb <= {7'd0, colour[7:0]} * {8'd0, pct_use};
                end
            end
            OP_SC2: begin
                r_red    <= q_r[26:19];
                r_green  <= q_g[26:19];
                r_blue   <= q_b[26:19];
                r_ostate <= r_shown;
            end
            default: begin
            end
        endcase
    end

    assign o_st.func      = r_func;
    assign o_st.eff_state = eff_state;
    assign o_st.shown     = r_shown;
    assign o_st.out_busy  = r_ovalid & ~i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_shown_state = r_ostate;

endmodule

`default_nettype wire

@@ sv/status_led_pattern_generator.sv @@
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: func; tdata: now_ms, new_state,
//                                                     hold_ms
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: red, green, blue, shown_state
// cfg       in         i_cfg_wr_en                    i_cfg_wr_data: brightness percent
//
// One item is worked on at a time; a set-state item runs only the apply step, a steady
// colour then runs the scaling steps, a blinking colour first divides the time by its
// half period and a breathing (boot) colour also runs the fraction, angle and sine steps.
// The single shared 32x32 multiplier carries the two reciprocal divisions by the
// breath period and the sine polynomial.
// Reset gives the boot state, no hold expiry and a brightness of 15 percent.
// A colour waits in the output register while m_axis_tready is low; the next
// item is still taken and runs up to its final step, where it waits.
`default_nettype none

module status_led_pattern_generator import sled_pkg::*; #(
    parameter int unsigned BREATH_PERIOD_MS = 1500
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // now_ms[31:0], new_state[34:32], hold_ms[66:35]
    input  wire logic        s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // red[7:0], green[15:8], blue[23:16],
                                            // shown_state[26:24]
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data
);

    t_cmd        cmd;
    t_status     st;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  shown_state;

    // Step sequencer
    sled_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Arithmetic, state and output register
    sled_dp #(
        .BREATH_PERIOD_MS (BREATH_PERIOD_MS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_func        (s_axis_tuser),
        .i_now_ms      (s_axis_tdata[31:0]),
        .i_new_state   (s_axis_tdata[34:32]),
        .i_hold_ms     (s_axis_tdata[66:35]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_red         (red),
        .o_green       (green),
        .o_blue        (blue),
        .o_shown_state (shown_state)
    );

    assign m_axis_tdata = {5'd0, shown_state, blue, green, red};

    // The final step never overwrites a colour that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_SC2) |-> !st.out_busy)
        else $error("output register overwritten while full");

    // An accepted item keeps the input closed in the cycle that follows
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is at work");

    // A delivered colour always names a defined display state
    a_shown_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[26:24] <= DS_SAVING))
        else $error("undefined display state on output");

endmodule

`default_nettype wire

@@ tb/status_led_pattern_generator_tb.sv @@
`timescale 1ns / 100ps

module status_led_pattern_generator_tb;
    import sled_pkg::*;

    localparam int unsigned BREATH_MS      = 1500;
    localparam int unsigned SCAN_HALF_MS   = 350;
    localparam int unsigned NEWDEV_HALF_MS = 600;
    localparam int unsigned BRIGHT_MAX     = 100;
    localparam logic [6:0]  BRIGHT_RESET   = 7'd15;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          LIMIT_CYCLES   = 300000;
    localparam int          NUM_DIR        = 26;
    localparam int          NUM_PHASES     = 8;
    localparam int          PHASE_ITEMS    = 88;

    // Item kinds carried on tuser
    localparam logic FN_RENDER    = 1'b0;
    localparam logic FN_SET_STATE = 1'b1;

    // State codes that the block must ignore
    localparam t_disp DS_BAD_LO = 3'd6;
    localparam t_disp DS_BAD_HI = 3'd7;

    // Base colours as 0xRRGGBB
    localparam logic [23:0] RGB_BLUE   = 24'h1040FF;
    localparam logic [23:0] RGB_GREEN  = 24'h00C040;
    localparam logic [23:0] RGB_YELLOW = 24'hC0A000;
    localparam logic [23:0] RGB_VIOLET = 24'h8000C0;
    localparam logic [23:0] RGB_CYAN   = 24'h00C0C0;

    // Fixed-point sine constants, Q30
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned SIN_C1  = 64'd1686629713;
    localparam longint unsigned SIN_C3  = 64'd693598668;
    localparam longint unsigned SIN_C5  = 64'd85569306;
    localparam longint unsigned SIN_C7  = 64'd5026994;
    localparam longint unsigned SIN_C9  = 64'd172272;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_disp      shown;
    } t_led_colour;

    typedef struct packed {
        logic        fn;
        logic [31:0] now;
        t_disp       st;
        logic [31:0] hold;
        logic        typed;
        t_led_colour want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // now_ms[31:0], new_state[34:32], hold_ms[66:35]
    logic        s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // red[7:0], green[15:8], blue[23:16], shown_state[26:24]
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;

    // Own copy of the block's state
    t_disp       disp_state;
    logic [31:0] expiry_at;
    logic [6:0]  bright_pct;
    logic [15:0] breath_lut [0:BREATH_MS-1];

    t_led_colour colour_q [$];
    logic        item_typed;
    t_led_colour item_want;
    logic [31:0] clock_ms;
    bit          tx_burst;
    bit          rx_burst;
    int          mismatches;
    int          cycle_count;
    t_dir_row    dir_rows [0:NUM_DIR-1];

    status_led_pattern_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Q30 product, truncated.
    function automatic longint unsigned q30_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // Breathing level in Q0.16 for one millisecond of the period.
    function automatic logic [15:0] sine_level(input int unsigned idx);
        longint unsigned turn;
        longint unsigned f;
        longint unsigned f2;
        longint unsigned s;
        longint unsigned lvl;
        int unsigned     quad;
        turn = (longint'(idx) << 32) / BREATH_MS;
        quad = int'((turn >> 30) & 64'd3);
        f = turn & (Q30_ONE - 1);
        if (quad == 1 || quad == 3) begin
            f = Q30_ONE - f;
        end
        f2 = q30_mul(f, f);
        s = SIN_C7 - q30_mul(f2, SIN_C9);
        s = SIN_C5 - q30_mul(f2, s);
        s = SIN_C3 - q30_mul(f2, s);
        s = SIN_C1 - q30_mul(f2, s);
        s = q30_mul(f, s);
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        lvl = (quad < 2) ? (Q30_ONE + s) : (Q30_ONE - s);
        return 16'((lvl * 64'd65535 + Q30_ONE) >> 31);
    endfunction

    function automatic logic [7:0] scale_channel(input logic [7:0] ch, input logic [31:0] pct);
        logic [31:0] prod;
        prod = (32'(ch) * pct) / BRIGHT_MAX;
        return prod[7:0];
    endfunction

    // Advances the state for one item; returns 1 with the colour when a render gives one.
    function automatic bit next_colour(input logic fn, input logic [31:0] now,
                                       input t_disp ns, input logic [31:0] hold,
                                       output t_led_colour c);
        logic [31:0] pct;
        logic [23:0] rgb;
        c = '0;
        if (fn == FN_SET_STATE) begin
            if (ns <= DS_SAVING) begin
                disp_state = ns;
                expiry_at  = (hold != 32'd0) ? now + hold : 32'd0;
            end
            return 1'b0;
        end
        // The hold is tested with a plain compare, with no care for wrap.
        if (expiry_at != 32'd0 && now >= expiry_at) begin
            disp_state = DS_READY;
            expiry_at  = 32'd0;
        end
        pct = 32'(bright_pct);
        rgb = 24'h0;
        case (disp_state)
            DS_BOOT: begin
                pct = (32'(bright_pct) * 32'(breath_lut[now % BREATH_MS])) >> 16;
                rgb = RGB_BLUE;
            end
            DS_READY: rgb = RGB_BLUE;
            DS_SCAN: begin
                if (((now / SCAN_HALF_MS) & 32'd1) == 32'd0) begin
                    rgb = RGB_GREEN;
                end
            end
            DS_NEWDEV: begin
                if (((now / NEWDEV_HALF_MS) & 32'd1) == 32'd0) begin
                    rgb = RGB_YELLOW;
                end
            end
            DS_PORTAL: rgb = RGB_VIOLET;
            default:   rgb = RGB_CYAN;
        endcase
        c.red   = scale_channel(rgb[23:16], pct);
        c.green = scale_channel(rgb[15:8], pct);
        c.blue  = scale_channel(rgb[7:0], pct);
        c.shown = disp_state;
        return 1'b1;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Checks colours leaving the block and predicts colours for items entering it.
    always @(posedge i_clk) begin
        t_led_colour got;
        t_led_colour want;
        if (!i_rst_n) begin
            disp_state = DS_BOOT;
            expiry_at  = 32'd0;
            bright_pct = BRIGHT_RESET;
            colour_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                bright_pct = (i_cfg_wr_data > BRIGHT_MAX) ? 7'(BRIGHT_MAX) : i_cfg_wr_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.red   = m_axis_tdata[7:0];
                got.green = m_axis_tdata[15:8];
                got.blue  = m_axis_tdata[23:16];
                got.shown = m_axis_tdata[26:24];
                if (colour_q.size() == 0) begin
                    $display("%0t: colour with none expected, actual %0d %0d %0d state %0d",
                             $time, got.red, got.green, got.blue, got.shown);
                    mismatches++;
                end else begin
                    want = colour_q.pop_front();
                    report_field("red", want.red, got.red);
                    report_field("green", want.green, got.green);
                    report_field("blue", want.blue, got.blue);
                    report_field("shown_state", 8'(want.shown), 8'(got.shown));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (next_colour(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[34:32],
                                s_axis_tdata[66:35], want)) begin
                    if (item_typed) begin
                        want = item_want;
                    end
                    colour_q.push_back(want);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: a random stall before each colour, with stretches of none.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        rx_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 8);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) begin
                @(posedge i_clk);
            end
        end
    end

    // Presents one item after a random gap and waits until it is taken.
    task automatic send_item(input logic fn, input logic [31:0] now, input t_disp st,
                             input logic [31:0] hold, input logic typed,
                             input t_led_colour want);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {5'd0, hold, st, now};
        item_typed    <= typed;
        item_want     <= want;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) begin
            @(posedge i_clk);
        end
    endtask

    // Stops the sender and lets every colour out, then lets a set-state item finish.
    task automatic settle_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (colour_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_brightness(input logic [6:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly renders and state changes on a running clock, with some noise.
    task automatic run_random_items(input int n);
        int          count;
        int          pick;
        logic        fn;
        logic [31:0] now;
        logic [31:0] hold;
        t_disp       st;
        count = 0;
        while (count < n) begin
            clock_ms += $urandom_range(0, 400);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                fn   = 1'($urandom_range(0, 1));
                now  = $urandom;
                st   = 3'($urandom_range(0, 7));
                hold = $urandom;
            end else if (pick < 40) begin
                fn  = FN_SET_STATE;
                now = clock_ms;
                if ($urandom_range(0, 9) == 0) begin
                    st = 3'($urandom_range(DS_BAD_LO, DS_BAD_HI));
                end else begin
                    st = 3'($urandom_range(DS_BOOT, DS_SAVING));
                end
                case ($urandom_range(0, 3))
                    0:       hold = 32'd0;
                    1, 2:    hold = $urandom_range(1, 2500);
                    default: hold = $urandom;
                endcase
            end else begin
                fn   = FN_RENDER;
                now  = clock_ms;
                st   = 3'($urandom_range(0, 7));
                hold = $urandom;
            end
            send_item(fn, now, st, hold, 1'b0, '0);
            if (!(fn == FN_SET_STATE && st > DS_SAVING)) begin
                count++;
            end
            // Now and then the sender holds off until every colour has come back.
            if ($urandom_range(0, 99) == 0) begin
                settle_block();
            end
        end
    endtask

    initial begin
        logic [6:0] levels [0:NUM_PHASES-1];
        for (int i = 0; i < BREATH_MS; i++) begin
            breath_lut[i] = sine_level(i);
        end
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        item_typed    = 1'b0;
        item_want     = '0;
        tx_burst      = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;

        // Directed items at the reset brightness of 15 percent.
        dir_rows = '{
            '{FN_RENDER,    32'd0,          DS_BOOT,   32'd0,          1'b1,
              '{8'd1, 8'd4, 8'd17, DS_BOOT}},
            '{FN_RENDER,    32'd375,        DS_BOOT,   32'd0,          1'b0, '0},
            '{FN_RENDER,    32'hFFFFFFFF,   DS_BOOT,   32'd0,          1'b0, '0},
            // Unknown state codes leave state and hold untouched.
            '{FN_SET_STATE, 32'd0,          DS_BAD_HI, 32'hFFFFFFFF,   1'b0, '0},
            '{FN_RENDER,    32'd5,          DS_BOOT,   32'd0,          1'b0, '0},
            '{FN_SET_STATE, 32'd0,          DS_BAD_LO, 32'd0,          1'b0, '0},
            '{FN_SET_STATE, 32'd0,          DS_READY,  32'd0,          1'b0, '0},
            '{FN_RENDER,    32'hFFFFFFFF,   DS_BOOT,   32'd0,          1'b1,
              '{8'd2, 8'd9, 8'd38, DS_READY}},
            '{FN_SET_STATE, 32'd0,          DS_SCAN,   32'd0,          1'b0, '0},
            '{FN_RENDER,    32'd0,          DS_BOOT,   32'd0,          1'b1,
              '{8'd0, 8'd28, 8'd9, DS_SCAN}},
            '{FN_RENDER,    32'd350,        DS_BOOT,   32'd0,          1'b1,
              '{8'd0, 8'd0, 8'd0, DS_SCAN}},
            '{FN_SET_STATE, 32'd0,          DS_NEWDEV, 32'd0,          1'b0, '0},
            '{FN_RENDER,    32'd0,          DS_BOOT,   32'd0,          1'b1,
              '{8'd28, 8'd24, 8'd0, DS_NEWDEV}},
            '{FN_RENDER,    32'd600,        DS_BOOT,   32'd0,          1'b1,
              '{8'd0, 8'd0, 8'd0, DS_NEWDEV}},
            '{FN_SET_STATE, 32'd0,          DS_PORTAL, 32'd0,          1'b0, '0},
            '{FN_RENDER,    32'd123,        DS_BOOT,   32'd0,          1'b1,
              '{8'd19, 8'd0, 8'd28, DS_PORTAL}},
            // A hold runs out exactly when the time reaches its end.
            '{FN_SET_STATE, 32'd1000,       DS_SAVING, 32'd500,        1'b0, '0},
            '{FN_RENDER,    32'd1499,       DS_BOOT,   32'd0,          1'b1,
              '{8'd0, 8'd28, 8'd28, DS_SAVING}},
            '{FN_RENDER,    32'd1500,       DS_BOOT,   32'd0,          1'b1,
              '{8'd2, 8'd9, 8'd38, DS_READY}},
            // A hold whose end wraps to zero never runs out.
            '{FN_SET_STATE, 32'hFFFFFFFF,   DS_PORTAL, 32'd1,          1'b0, '0},
            '{FN_RENDER,    32'hFFFFFFFF,   DS_BOOT,   32'd0,          1'b1,
              '{8'd19, 8'd0, 8'd28, DS_PORTAL}},
            // A wrapped end is compared without regard to wrap.
            '{FN_SET_STATE, 32'hFFFFFF00,   DS_NEWDEV, 32'hFFFFFFFF,   1'b0, '0},
            '{FN_RENDER,    32'd10,         DS_BOOT,   32'd0,          1'b1,
              '{8'd28, 8'd24, 8'd0, DS_NEWDEV}},
            '{FN_RENDER,    32'hFFFFFFFF,   DS_BOOT,   32'd0,          1'b1,
              '{8'd2, 8'd9, 8'd38, DS_READY}},
            '{FN_SET_STATE, 32'd0,          DS_BOOT,   32'd0,          1'b0, '0},
            '{FN_RENDER,    32'd750,        DS_BOOT,   32'd0,          1'b0, '0}
        };

        // Extremes of brightness, saturating writes and a few others.
        levels = '{7'd100, 7'd0, 7'd127, 7'd1, 7'($urandom_range(0, 127)), 7'd101, 7'd99,
                   7'($urandom_range(2, 98))};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            send_item(dir_rows[r].fn, dir_rows[r].now, dir_rows[r].st, dir_rows[r].hold,
                      dir_rows[r].typed, dir_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_block();
            write_brightness(levels[p]);
            clock_ms = $urandom;
            run_random_items(PHASE_ITEMS);
        end

        settle_block();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sled_pkg.sv
sv/sled_ctrl.sv
sv/sled_dp.sv
sv/status_led_pattern_generator.sv
tb/status_led_pattern_generator_tb.sv
